FILE: design/assert_macros.svh
// Assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is held
`define TCG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also runs through reset
`define TCG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/tcg_pkg.sv
// Types and constants for the text console glyph renderer
`timescale 1ns / 1ps
`default_nettype none
package tcg_pkg;

  localparam int GLYPH_WIDTH      = 8;
  localparam int MAX_GLYPH_HEIGHT = 32;
  localparam int MAX_GLYPHS       = 512;
  localparam int MEM_DEPTH        = MAX_GLYPHS * MAX_GLYPH_HEIGHT;
  localparam int MEM_AW           = $clog2(MEM_DEPTH);
  localparam int ROW_W            = $clog2(MAX_GLYPH_HEIGHT);

  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_QMARK = 8'h3F;

  localparam logic MODE_CHAR  = 1'b0;
  localparam logic MODE_LOAD  = 1'b1;
  localparam logic KIND_ROW   = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  localparam logic [9:0] COLS_MAX  = 10'd512;
  localparam logic [8:0] ROWS_MAX  = 9'd256;
  localparam logic [5:0] HEIGHT_MAX = 6'(MAX_GLYPH_HEIGHT);
  localparam logic [9:0] COUNT_MIN = 10'd256;
  localparam logic [9:0] COUNT_MAX = 10'(MAX_GLYPHS);

  typedef enum logic [2:0] {
    REG_ENABLE  = 3'd0,
    REG_COLUMNS = 3'd1,
    REG_ROWS    = 3'd2,
    REG_HEIGHT  = 3'd3,
    REG_COUNT   = 3'd4,
    REG_FG      = 3'd5,
    REG_BG      = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic        mode;
    logic [7:0]  char_code;
    logic [13:0] glyph_addr;
    logic [7:0]  glyph_byte;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic [11:0] pixel_x;
    logic [12:0] pixel_y;
    logic [7:0]  row_bits;
    logic [23:0] fore_color;
    logic [23:0] back_color;
    logic        last;
  } out_t;

  // Clamped view of the configuration registers
  typedef struct packed {
    logic        enable;
    logic [9:0]  cols;
    logic [8:0]  rows;
    logic [5:0]  height;
    logic [9:0]  count;
    logic [23:0] fg;
    logic [23:0] bg;
  } cfg_t;

  // Request from the front to the back
  typedef struct packed {
    logic              is_load;
    logic              draw;
    logic              clear;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        glyph_byte;
    logic [11:0]       px;
    logic [12:0]       py;
    logic [5:0]        height;
  } cmd_t;

endpackage
`default_nettype wire

FILE: design/tcg_cmd_queue.sv
// Two-entry request queue between the front and the back
`timescale 1ns / 1ps
`default_nettype none
module tcg_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tcg_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output tcg_pkg::cmd_t pop_data
);
  import tcg_pkg::*;

  cmd_t       slot_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full     = (cnt_r == 2'd2);
  assign valid    = (cnt_r != 2'd0);
  assign pop_data = slot_r[rp_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

FILE: design/tcg_front.sv
// Front: accepts requests, tracks the cursor and classifies each character
`timescale 1ns / 1ps
`default_nettype none
module tcg_front (
  input  logic          clk,
  input  logic          rst_n,
  input  tcg_pkg::in_t  in_data,
  input  logic          in_push,
  output logic          in_full,
  input  tcg_pkg::cfg_t cfg,
  output tcg_pkg::cmd_t cmd_data,
  output logic          cmd_push,
  input  logic          cmd_full
);
  import tcg_pkg::*;

  logic [8:0]  col_r, col_nxt;
  logic [7:0]  line_r, line_nxt;
  logic        accept, is_char, draw, clr;
  logic [9:0]  col_inc, col_t;
  logic [8:0]  line_t;
  logic [8:0]  draw_col;
  logic [7:0]  idx;
  logic [13:0] py_full, base_full;

  assign in_full = cmd_full;
  assign accept  = in_push && !cmd_full;

  always_comb begin
    is_char  = (in_data.mode == MODE_CHAR) && cfg.enable && (in_data.char_code != CHAR_NUL);
    col_inc  = {1'b0, col_r} + 10'd1;
    col_t    = {1'b0, col_r};
    line_t   = {1'b0, line_r};
    draw_col = col_r;
    draw     = 1'b0;
    idx      = in_data.char_code;
    if (in_data.char_code == CHAR_NL) begin
      col_t  = 10'd0;
      line_t = {1'b0, line_r} + 9'd1;
    end else if (in_data.char_code == CHAR_BS) begin
      // step back and blank the cell; nothing to draw at column zero
      if (col_r != 9'd0) begin
        draw_col = col_r - 9'd1;
        col_t    = {1'b0, draw_col};
        draw     = 1'b1;
        idx      = CHAR_SPACE;
      end
    end else begin
      draw = 1'b1;
      if ({2'b00, in_data.char_code} >= cfg.count) begin
        idx = CHAR_QMARK;
      end
      col_t = col_inc;
      if (col_inc >= cfg.cols) begin
        col_t  = 10'd0;
        line_t = {1'b0, line_r} + 9'd1;
      end
    end
    clr = (line_t >= cfg.rows);
    if (clr) begin
      col_t  = 10'd0;
      line_t = 9'd0;
    end
    col_nxt  = (accept && is_char) ? col_t[8:0] : col_r;
    line_nxt = (accept && is_char) ? line_t[7:0] : line_r;
  end

  // Row start and glyph base; both products stay inside 14 bits
  assign py_full   = {6'd0, line_r} * {8'd0, cfg.height};
  assign base_full = {6'd0, idx} * {8'd0, cfg.height};

  always_comb begin
    cmd_data.is_load    = (in_data.mode == MODE_LOAD);
    cmd_data.draw       = draw;
    cmd_data.clear      = clr;
    cmd_data.addr       = cmd_data.is_load ? in_data.glyph_addr[MEM_AW-1:0]
                                           : base_full[MEM_AW-1:0];
    cmd_data.glyph_byte = in_data.glyph_byte;
    cmd_data.px         = {draw_col, 3'b000};
    cmd_data.py         = py_full[12:0];
    cmd_data.height     = cfg.height;
    cmd_push = accept && (cmd_data.is_load || (is_char && (draw || clr)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= 9'd0;
      line_r <= 8'd0;
    end else begin
      col_r  <= col_nxt;
      line_r <= line_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: design/tcg_back.sv
// Back: glyph memory, row sequencer and result queue
`timescale 1ns / 1ps
`default_nettype none
module tcg_back (
  input  logic          clk,
  input  logic          rst_n,
  input  tcg_pkg::cfg_t cfg,
  input  logic          cmd_valid,
  input  tcg_pkg::cmd_t cmd_data,
  output logic          cmd_pop,
  output logic          out_empty,
  input  logic          out_pop,
  output tcg_pkg::out_t out_data
);
  import tcg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ROWS  = 3'b010,
    S_CLEAR = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  cmd_t             cur_r, cur_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             row_final, credit, issue, issue_clear, mem_we;
  logic [MEM_AW-1:0] rd_addr;

  logic [7:0]       mem [MEM_DEPTH];
  logic [7:0]       rd_data_r;

  logic             st_v_r, st_clear_r, st_last_r;
  logic [11:0]      st_px_r;
  logic [12:0]      st_py_r;

  out_t             oq_r [OQ_DEPTH];
  out_t             oq_in;
  logic [OQ_AW-1:0] wp_r, rp_r;
  logic [OQ_AW:0]   cnt_r, cnt_nxt;
  logic             pop_fire;

  assign row_final = ({1'b0, row_r} + 6'd1) == cur_r.height;
  // count the row already in flight so the queue never overruns
  assign credit    = (cnt_r + {{OQ_AW{1'b0}}, st_v_r}) < (OQ_AW + 1)'(OQ_DEPTH);
  assign rd_addr   = cur_r.addr + MEM_AW'(row_r);

  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    row_nxt     = row_r;
    cmd_pop     = 1'b0;
    mem_we      = 1'b0;
    issue       = 1'b0;
    issue_clear = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd_data.is_load) begin
            mem_we = 1'b1;
          end else begin
            cur_nxt   = cmd_data;
            row_nxt   = '0;
            state_nxt = cmd_data.draw ? S_ROWS : S_CLEAR;
          end
        end
      end
      S_ROWS: begin
        if (credit) begin
          issue = 1'b1;
          if (row_final) begin
            row_nxt   = '0;
            state_nxt = cur_r.clear ? S_CLEAR : S_IDLE;
          end else begin
            row_nxt = row_r + 1'b1;
          end
        end
      end
      S_CLEAR: begin
        if (credit) begin
          issue_clear = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cmd_data.addr] <= cmd_data.glyph_byte;
    end
    if (issue) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    row_r      <= row_nxt;
    st_clear_r <= issue_clear;
    st_last_r  <= issue_clear || (row_final && !cur_r.clear);
    st_px_r    <= cur_r.px;
    st_py_r    <= cur_r.py + 13'(row_r);
  end

  always_comb begin
    oq_in.kind       = st_clear_r ? KIND_CLEAR : KIND_ROW;
    oq_in.pixel_x    = st_clear_r ? 12'd0 : st_px_r;
    oq_in.pixel_y    = st_clear_r ? 13'd0 : st_py_r;
    oq_in.row_bits   = st_clear_r ? 8'd0 : rd_data_r;
    oq_in.fore_color = st_clear_r ? 24'd0 : cfg.fg;
    oq_in.back_color = cfg.bg;
    oq_in.last       = st_last_r;
  end

  assign out_empty = (cnt_r == '0);
  assign out_data  = oq_r[rp_r];
  assign pop_fire  = out_pop && !out_empty;
  assign cnt_nxt   = cnt_r + {{OQ_AW{1'b0}}, st_v_r} - {{OQ_AW{1'b0}}, pop_fire};

  always_ff @(posedge clk) begin
    if (st_v_r) begin
      oq_r[wp_r] <= oq_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_v_r  <= 1'b0;
      wp_r    <= '0;
      rp_r    <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      st_v_r  <= issue || issue_clear;
      wp_r    <= st_v_r ? wp_r + 1'b1 : wp_r;
      rp_r    <= pop_fire ? rp_r + 1'b1 : rp_r;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: design/text_console_glyph_renderer.sv
// A request passes the front, the two-entry request queue, the back's current-request register,
// the glyph memory read and row staging registers and the result queue before its first result is visible.
// The back takes a new request only once it has issued every row and clear of the last one.
// Its single glyph memory read port gives one row a cycle while the result queue has room.
// Reset (rst_n low, synchronous) homes the cursor, empties both queues and restores
// register defaults; glyph memory contents are kept and undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
module text_console_glyph_renderer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  tcg_pkg::in_t        in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output tcg_pkg::out_t       out_data,
  input  logic                cfg_we,
  input  tcg_pkg::reg_idx_t   cfg_index,
  input  logic [23:0]         cfg_wdata
);
  import tcg_pkg::*;

  logic        enable_r;
  logic [9:0]  cols_r, count_r;
  logic [8:0]  rows_r;
  logic [5:0]  height_r;
  logic [23:0] fg_r, bg_r;
  cfg_t        cfg;

  cmd_t        fq_data, bq_data;
  logic        fq_push, fq_full, bq_valid, bq_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      cols_r   <= 10'd80;
      rows_r   <= 9'd30;
      height_r <= 6'd16;
      count_r  <= 10'd256;
      fg_r     <= 24'hFFFFFF;
      bg_r     <= 24'h000000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE:  enable_r <= cfg_wdata[0];
        REG_COLUMNS: cols_r   <= cfg_wdata[9:0];
        REG_ROWS:    rows_r   <= cfg_wdata[8:0];
        REG_HEIGHT:  height_r <= cfg_wdata[5:0];
        REG_COUNT:   count_r  <= cfg_wdata[9:0];
        REG_FG:      fg_r     <= cfg_wdata;
        REG_BG:      bg_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Hold the geometry and glyph count registers inside their usable ranges
  always_comb begin
    cfg.enable = enable_r;
    cfg.cols   = (cols_r == 10'd0) ? 10'd1 : ((cols_r > COLS_MAX) ? COLS_MAX : cols_r);
    cfg.rows   = (rows_r == 9'd0) ? 9'd1 : ((rows_r > ROWS_MAX) ? ROWS_MAX : rows_r);
    cfg.height = (height_r == 6'd0) ? 6'd1
               : ((height_r > HEIGHT_MAX) ? HEIGHT_MAX : height_r);
    cfg.count  = (count_r < COUNT_MIN) ? COUNT_MIN
               : ((count_r > COUNT_MAX) ? COUNT_MAX : count_r);
    cfg.fg     = fg_r;
    cfg.bg     = bg_r;
  end

  tcg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .in_push  (in_push),
    .in_full  (in_full),
    .cfg      (cfg),
    .cmd_data (fq_data),
    .cmd_push (fq_push),
    .cmd_full (fq_full)
  );

  tcg_cmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fq_push),
    .push_data (fq_data),
    .full      (fq_full),
    .pop       (bq_pop),
    .valid     (bq_valid),
    .pop_data  (bq_data)
  );

  tcg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd_valid (bq_valid),
    .cmd_data  (bq_data),
    .cmd_pop   (bq_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

FILE: design/tcg_checker.sv
// Port-level checks for the text console glyph renderer
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tcg_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_full,
  input wire logic          out_empty,
  input wire logic          out_pop,
  input wire tcg_pkg::out_t out_data
);
  import tcg_pkg::*;

  `TCG_ASSERT(a_out_hold, (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)), "result changed while stalled")
  `TCG_ASSERT(a_clear_form, (!out_empty && out_data.kind == KIND_CLEAR) |-> (out_data.last && out_data.pixel_x == 12'd0 && out_data.pixel_y == 13'd0 && out_data.row_bits == 8'd0 && out_data.fore_color == 24'd0), "malformed clear result")
  `TCG_ASSERT(a_cell_align, !out_empty |-> (out_data.pixel_x[2:0] == 3'd0), "row not on a cell boundary")
  `TCG_ASSERT_ALWAYS(a_reset_state, $past(!rst_n) |-> (out_empty && !in_full), "queues not empty after reset")

endmodule

bind text_console_glyph_renderer tcg_checker u_tcg_checker (.*);
`default_nettype wire
